[sv/sedf_pkg.sv]
// Shared types, character codes and helpers for the STX/ETX response deframer.
package sedf_pkg;

  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [2:0] NAK_TAIL = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_SUM1 = 3'd2,
    PH_SUM2 = 3'd3,
    PH_NAK  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    K_PAYLOAD = 3'd0,
    K_GOOD    = 3'd1,
    K_BAD     = 3'd2,
    K_NAK     = 3'd3,
    K_OVER    = 3'd4,
    K_LEAD    = 3'd5
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] value;
  } result_t;

  // One nibble as an uppercase ASCII hex digit.
  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h41 + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage

[sv/sedf_core.sv]
// Frame state machine: phase, running sum, byte count and per-byte result.
module sedf_core #(
  parameter int MAX_FRAME    = 256,
  parameter int HEADER_CHARS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output sedf_pkg::result_t   res
);

  localparam int CW = $clog2(MAX_FRAME);
  localparam logic [CW-1:0] LAST_IDX = CW'(MAX_FRAME - 1);
  localparam logic [CW:0]   HDR      = (CW+1)'(HEADER_CHARS);

  sedf_pkg::phase_t phase, phase_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]    first_sum_char, first_sum_char_next;
  logic [2:0]    nak_remaining, nak_remaining_next;

  logic [7:0] sum_add;
  logic       at_last;
  logic       past_header;
  logic [2:0] nak_dec;
  logic       sum_match;

  assign sum_add     = running_sum + rx_byte;
  assign at_last     = (byte_count == LAST_IDX);
  assign past_header = ({1'b0, byte_count} >= HDR);
  assign nak_dec     = (nak_remaining != 3'd0) ? nak_remaining - 3'd1 : 3'd0;
  assign sum_match   = (first_sum_char == sedf_pkg::hex_upper(running_sum[7:4])) &&
                       (rx_byte == sedf_pkg::hex_upper(running_sum[3:0]));

  always_comb begin
    phase_next          = phase;
    running_sum_next    = running_sum;
    byte_count_next     = byte_count;
    first_sum_char_next = first_sum_char;
    nak_remaining_next  = nak_remaining;
    if (step) begin
      unique case (phase)
        sedf_pkg::PH_IDLE: begin
          if (rx_byte == sedf_pkg::CH_STX) begin
            phase_next       = sedf_pkg::PH_BODY;
            running_sum_next = 8'd0;
            byte_count_next  = '0;
          end else if (rx_byte == sedf_pkg::CH_NAK) begin
            phase_next         = sedf_pkg::PH_NAK;
            nak_remaining_next = sedf_pkg::NAK_TAIL;
          end
        end
        sedf_pkg::PH_BODY: begin
          running_sum_next = sum_add;
          if (at_last) begin
            phase_next      = sedf_pkg::PH_IDLE;
            byte_count_next = '0;
          end else begin
            byte_count_next = byte_count + 1'b1;
            if (rx_byte == sedf_pkg::CH_ETX) begin
              phase_next = sedf_pkg::PH_SUM1;
            end
          end
        end
        sedf_pkg::PH_SUM1: begin
          first_sum_char_next = rx_byte;
          phase_next          = sedf_pkg::PH_SUM2;
        end
        sedf_pkg::PH_SUM2: begin
          phase_next = sedf_pkg::PH_IDLE;
        end
        sedf_pkg::PH_NAK: begin
          nak_remaining_next = nak_dec;
          if (nak_dec == 3'd0) begin
            phase_next = sedf_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = sedf_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.valid = 1'b0;
    res.kind  = sedf_pkg::K_PAYLOAD;
    res.value = 8'd0;
    unique case (phase)
      sedf_pkg::PH_IDLE: begin
        if (rx_byte != sedf_pkg::CH_STX && rx_byte != sedf_pkg::CH_NAK) begin
          res.valid = 1'b1;
          res.kind  = sedf_pkg::K_LEAD;
        end
      end
      sedf_pkg::PH_BODY: begin
        if (at_last) begin
          res.valid = 1'b1;
          res.kind  = sedf_pkg::K_OVER;
        end else if (rx_byte != sedf_pkg::CH_ETX && past_header) begin
          res.valid = 1'b1;
          res.value = rx_byte;
        end
      end
      sedf_pkg::PH_SUM1: begin
        res.valid = 1'b0;
      end
      sedf_pkg::PH_SUM2: begin
        res.valid = 1'b1;
        res.kind  = sum_match ? sedf_pkg::K_GOOD : sedf_pkg::K_BAD;
        res.value = running_sum;
      end
      sedf_pkg::PH_NAK: begin
        if (nak_dec == 3'd0) begin
          res.valid = 1'b1;
          res.kind  = sedf_pkg::K_NAK;
        end
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sedf_pkg::PH_IDLE;
      running_sum    <= 8'd0;
      byte_count     <= '0;
      first_sum_char <= 8'd0;
      nak_remaining  <= 3'd0;
    end else begin
      phase          <= phase_next;
      running_sum    <= running_sum_next;
      byte_count     <= byte_count_next;
      first_sum_char <= first_sum_char_next;
      nak_remaining  <= nak_remaining_next;
    end
  end

`ifndef SYNTHESIS
  // NAK tail counter is live whenever we sit in the NAK phase
  a_nak_live: assert property (@(posedge clk) disable iff (rst)
    phase == sedf_pkg::PH_NAK |-> nak_remaining != 3'd0)
    else $error("NAK phase with empty tail count");

  // the byte count is cleared on the overflow word
  a_over_clear: assert property (@(posedge clk) disable iff (rst)
    step && phase == sedf_pkg::PH_BODY && at_last |=>
      phase == sedf_pkg::PH_IDLE && byte_count == '0)
    else $error("overflow did not return to idle");
`endif

endmodule

[sv/ascii_stx_etx_response_deframer_top.sv]
// Top level: input register, frame core and output register for the deframer.
// Usage:
//   Slave channel s_* carries one received serial byte per word (tdata[7:0]).
//   Master channel m_* carries result words: tuser[2:0] kind, tdata[7:0] value.
//   Kinds: payload byte, frame good, checksum mismatch, NAK reply, overflow,
//   unexpected lead. Value is the payload byte or the computed sum, else 0.
//   A word in idle that is not STX or NAK gives an unexpected-lead result.
// Timing:
//   A word accepted is held in the input register; when the core takes it,
//   its result (if any) is registered into the output register and shown on
//   m_*. One word per cycle sustained while m_tready stays high; the
//   frame state update is a single add and compare per word.
// Stall:
//   While m_tvalid is high and m_tready low, the input register holds its word
//   and s_tready drops once that register is full; nothing is lost.
// Reset:
//   rst (synchronous, active high) empties both registers and returns the
//   frame state to idle with zero sum and count.
module ascii_stx_etx_response_deframer_top #(
  parameter int MAX_FRAME    = 256,
  parameter int HEADER_CHARS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] value
  output logic [2:0]  m_tuser    // [2:0] kind
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic [2:0] out_kind;
  logic [7:0] out_value;
  sedf_pkg::result_t res;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  sedf_core #(
    .MAX_FRAME    (MAX_FRAME),
    .HEADER_CHARS (HEADER_CHARS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (in_valid && advance),
    .rx_byte (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind  <= res.kind;
      out_value <= res.value;
    end
  end

  assign m_tdata = out_value;
  assign m_tuser = out_kind;

`ifndef SYNTHESIS
  // a stalled input word must stay put until the core takes it
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("input word lost under stall");

  // only payload and sum results carry a nonzero value
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_kind == sedf_pkg::K_NAK || out_kind == sedf_pkg::K_OVER ||
                 out_kind == sedf_pkg::K_LEAD) |-> out_value == 8'd0)
    else $error("nonzero value on status result");

  // a new result is only loaded from a live input word
  a_src: assert property (@(posedge clk) disable iff (rst)
    advance && !in_valid |=> !m_tvalid)
    else $error("result without input word");
`endif

endmodule
